// ===== rtl/rmts_pkg.sv =====
// Shared constants and types of the rate monotonic tick scheduler.
package rmts_pkg;

  localparam int SLOT_COUNT    = 4;
  localparam int NUM_TASKS_DEF = 4;

  localparam int TIME_W   = 32;
  localparam int WORK_W   = 16;
  localparam int TASK_W   = 2;
  localparam int CHOICE_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [WORK_W-1:0]   work_t;
  typedef logic [TASK_W-1:0]   task_t;
  typedef logic [CHOICE_W-1:0] choice_t;

  localparam choice_t IDLE_CODE = choice_t'(4);

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TASK0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TASK1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TASK2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TASK3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TASK0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TASK1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TASK2  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TASK3  = 3'd7;

  localparam work_t PERIOD_RESET = work_t'(1);
  localparam work_t BURST_RESET  = work_t'(0);

endpackage

// ===== rtl/rate_monotonic_tick_scheduler.sv =====
// Rate monotonic tick scheduler: releases, priority select and work countdown per tick.
// Each accepted request is one tick and yields one result in the next cycle from an
// output register; a new tick is taken every cycle while the result is being taken
// or the output register is empty, so the sustained rate is one tick per clock.
// Release compares, the four-way smallest-period select and the decrement all sit
// in one stage between the state registers and the output register.
module rate_monotonic_tick_scheduler #(
  parameter int NUM_TASKS = rmts_pkg::NUM_TASKS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmts_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rmts_pkg::TASK_W-1:0]           out_chosen_task,
  output logic                                  out_idle,
  output logic                                  out_switched,
  output logic [rmts_pkg::TIME_W-1:0]           out_tick_time
);
  import rmts_pkg::*;

  work_t   period_r [SLOT_COUNT];
  work_t   burst_r  [SLOT_COUNT];

  work_t   work_r   [NUM_TASKS];
  work_t   work_nxt [NUM_TASKS];
  time_t   rel_r    [NUM_TASKS];
  time_t   rel_nxt  [NUM_TASKS];
  time_t   time_r;
  time_t   time_nxt;
  choice_t last_r;
  choice_t last_nxt;

  logic    out_valid_r;
  task_t   chosen_r;
  task_t   chosen_nxt;
  logic    idle_r;
  logic    idle_nxt;
  logic    switched_r;
  logic    switched_nxt;
  time_t   tick_r;
  time_t   tick_nxt;

  logic    accept;

  time_t   t_cur;
  choice_t last_cur;
  work_t   work_rel [NUM_TASKS];
  logic    found;
  task_t   best_idx;
  work_t   best_per;
  choice_t choice;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        period_r[k] <= PERIOD_RESET;
        burst_r[k]  <= BURST_RESET;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PERIOD_TASK0: period_r[0] <= cfg_wdata;
        REG_PERIOD_TASK1: period_r[1] <= cfg_wdata;
        REG_PERIOD_TASK2: period_r[2] <= cfg_wdata;
        REG_PERIOD_TASK3: period_r[3] <= cfg_wdata;
        REG_BURST_TASK0:  burst_r[0]  <= cfg_wdata;
        REG_BURST_TASK1:  burst_r[1]  <= cfg_wdata;
        REG_BURST_TASK2:  burst_r[2]  <= cfg_wdata;
        REG_BURST_TASK3:  burst_r[3]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    t_cur    = in_restart ? '0 : time_r;
    last_cur = in_restart ? IDLE_CODE : last_r;
    for (int k = 0; k < NUM_TASKS; k++) begin
      work_rel[k] = in_restart ? '0 : work_r[k];
      rel_nxt[k]  = in_restart ? '0 : rel_r[k];
      if (t_cur == rel_nxt[k]) begin
        work_rel[k] = burst_r[k];
        rel_nxt[k]  = rel_nxt[k] + time_t'(period_r[k]);
      end
    end

    found    = 1'b0;
    best_idx = '0;
    best_per = '0;
    for (int k = 0; k < NUM_TASKS; k++) begin
      if (work_rel[k] != '0 && (!found || period_r[k] < best_per)) begin
        found    = 1'b1;
        best_idx = task_t'(k);
        best_per = period_r[k];
      end
    end

    for (int k = 0; k < NUM_TASKS; k++) begin
      work_nxt[k] = work_rel[k];
      if (found && best_idx == task_t'(k)) begin
        work_nxt[k] = work_rel[k] - work_t'(1);
      end
    end

    choice       = found ? {1'b0, best_idx} : IDLE_CODE;
    chosen_nxt   = found ? best_idx : '0;
    idle_nxt     = !found;
    switched_nxt = choice != last_cur;
    tick_nxt     = t_cur;
    last_nxt     = choice;
    time_nxt     = t_cur + time_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        work_r[k] <= '0;
        rel_r[k]  <= '0;
      end
      time_r      <= '0;
      last_r      <= IDLE_CODE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        for (int k = 0; k < NUM_TASKS; k++) begin
          work_r[k] <= work_nxt[k];
          rel_r[k]  <= rel_nxt[k];
        end
        time_r      <= time_nxt;
        last_r      <= last_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chosen_r   <= chosen_nxt;
      idle_r     <= idle_nxt;
      switched_r <= switched_nxt;
      tick_r     <= tick_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_task = chosen_r;
  assign out_idle        = idle_r;
  assign out_switched    = switched_r;
  assign out_tick_time   = tick_r;

endmodule

// ===== rtl/rmts_checker.sv =====
// Port-level checks of the rate monotonic tick scheduler and their binding.
module rmts_props (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_restart,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rmts_pkg::TASK_W-1:0] out_chosen_task,
  input logic                        out_idle,
  input logic [rmts_pkg::TIME_W-1:0] out_tick_time
);
  import rmts_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Request refused while result register is empty.");

  a_request_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted request produced no result.");

  a_restart_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=> out_tick_time == '0)
    else $error("Restart tick does not report time zero.");

  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> out_chosen_task == '0)
    else $error("Idle result carries a nonzero task.");

endmodule

bind rate_monotonic_tick_scheduler rmts_props u_rmts_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_restart      (in_restart),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_chosen_task (out_chosen_task),
  .out_idle        (out_idle),
  .out_tick_time   (out_tick_time)
);
